[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error(msg);

`endif

[hdl/pcd_pkg.sv]
package pcd_pkg;

    // Result codes carried on the output tuser.
    typedef enum logic [1:0] {
        KIND_IDAT    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_BAD_SIG = 2'd2,
        KIND_TRUNC   = 2'd3
    } kind_t;

    // Chunk type codes, big-endian ASCII.
    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    // Depth of the queue between parser and output stage.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // One result as it travels through the queue.
    typedef struct packed {
        logic [31:0] height;
        logic [31:0] width;
        logic [31:0] total;
        logic [7:0]  payload;
        kind_t       kind;
    } result_t;

    // Queue status handed to the back part and used by the top for s_tready.
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

    // The eight bytes of the file signature.
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            3'd7:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[hdl/pcd_front.sv]
module pcd_front
    import pcd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_accept,
    input  logic      in_eof,
    input  logic [7:0] in_byte,
    output logic      res_valid,
    output result_t   res
);

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  fcount_reg, fcount_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] ctype_reg, ctype_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic        first_reg, first_next;
    logic        hit;
    kind_t       kind;

    // Parser step for one request.
    always_comb begin
        phase_next  = phase_reg;
        fcount_next = fcount_reg;
        len_next    = len_reg;
        ctype_next  = ctype_reg;
        total_next  = total_reg;
        width_next  = width_reg;
        height_next = height_reg;
        first_next  = first_reg;
        hit         = 1'b0;
        kind        = KIND_IDAT;

        if (in_eof) begin
            // End of file: report by phase, then start over for a new file.
            case (phase_reg)
                PH_SIG: begin
                    hit  = 1'b1;
                    kind = KIND_BAD_SIG;
                end
                PH_LEN, PH_TYPE, PH_CRC: begin
                    hit  = 1'b1;
                    kind = KIND_DONE;
                end
                PH_DATA: begin
                    hit  = 1'b1;
                    kind = KIND_TRUNC;
                end
                default: begin
                    hit = 1'b0;
                end
            endcase
            phase_next  = PH_SIG;
            fcount_next = 3'd0;
            len_next    = 32'd0;
            ctype_next  = 32'd0;
            total_next  = 32'd0;
            width_next  = 32'd0;
            height_next = 32'd0;
            first_next  = 1'b1;
        end else begin
            case (phase_reg)
                PH_SIG: begin
                    if (in_byte != sig_byte(fcount_reg)) begin
                        hit        = 1'b1;
                        kind       = KIND_BAD_SIG;
                        phase_next = PH_DONE;
                    end else if (fcount_reg == 3'd7) begin
                        fcount_next = 3'd0;
                        len_next    = 32'd0;
                        phase_next  = PH_LEN;
                    end else begin
                        fcount_next = fcount_reg + 3'd1;
                    end
                end
                PH_LEN: begin
                    len_next = {len_reg[23:0], in_byte};
                    if (fcount_reg == 3'd3) begin
                        fcount_next = 3'd0;
                        ctype_next  = 32'd0;
                        phase_next  = PH_TYPE;
                    end else begin
                        fcount_next = fcount_reg + 3'd1;
                    end
                end
                PH_TYPE: begin
                    ctype_next = {ctype_reg[23:0], in_byte};
                    if (fcount_reg == 3'd3) begin
                        fcount_next = 3'd0;
                        if (ctype_next != TYPE_IHDR) begin
                            first_next = 1'b0;
                        end
                        if (len_reg == 32'd0) begin
                            first_next = 1'b0;
                            phase_next = PH_CRC;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end else begin
                        fcount_next = fcount_reg + 3'd1;
                    end
                end
                PH_DATA: begin
                    // The first eight bytes of a leading IHDR give width and height.
                    if (first_reg) begin
                        if (!fcount_reg[2]) begin
                            width_next = {width_reg[23:0], in_byte};
                        end else begin
                            height_next = {height_reg[23:0], in_byte};
                        end
                        if (fcount_reg == 3'd7) begin
                            first_next = 1'b0;
                        end
                        fcount_next = fcount_reg + 3'd1;
                    end
                    if (ctype_reg == TYPE_IDAT) begin
                        if (total_reg != 32'hFFFF_FFFF) begin
                            total_next = total_reg + 32'd1;
                        end
                        hit  = 1'b1;
                        kind = KIND_IDAT;
                    end
                    len_next = len_reg - 32'd1;
                    if (len_next == 32'd0) begin
                        first_next  = 1'b0;
                        fcount_next = 3'd0;
                        phase_next  = PH_CRC;
                    end
                end
                PH_CRC: begin
                    if (fcount_reg == 3'd3) begin
                        fcount_next = 3'd0;
                        if (ctype_reg == TYPE_IEND) begin
                            hit        = 1'b1;
                            kind       = KIND_DONE;
                            phase_next = PH_DONE;
                        end else begin
                            len_next   = 32'd0;
                            phase_next = PH_LEN;
                        end
                    end else begin
                        fcount_next = fcount_reg + 3'd1;
                    end
                end
                default: begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    // Result record: an end of file reports the state it found.
    always_comb begin
        res.kind    = kind;
        res.payload = (kind == KIND_IDAT) ? in_byte : 8'd0;
        res.total   = in_eof ? total_reg  : total_next;
        res.width   = in_eof ? width_reg  : width_next;
        res.height  = in_eof ? height_reg : height_next;
        res_valid   = in_accept && hit;
    end

    // Parser state, advanced once per accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SIG;
            fcount_reg <= 3'd0;
            len_reg    <= 32'd0;
            ctype_reg  <= 32'd0;
            total_reg  <= 32'd0;
            width_reg  <= 32'd0;
            height_reg <= 32'd0;
            first_reg  <= 1'b1;
        end else if (in_accept) begin
            phase_reg  <= phase_next;
            fcount_reg <= fcount_next;
            len_reg    <= len_next;
            ctype_reg  <= ctype_next;
            total_reg  <= total_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            first_reg  <= first_next;
        end
    end

endmodule

[hdl/pcd_queue.sv]
module pcd_queue
    import pcd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  result_t   push_data,
    input  logic      pop,
    output result_t   pop_data,
    output q_status_t status
);

    result_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    // Entry storage; no reset needed on the payload.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

[hdl/pcd_back.sv]
module pcd_back
    import pcd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  q_status_t q_status,
    input  result_t   q_data,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   out_data
);

    logic    valid_reg;
    result_t data_reg;

    // Refill the output register from a non-empty queue whenever it is empty or being taken.
    assign q_pop     = !q_status.empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= q_data;
        end
    end

endmodule

[hdl/png_chunk_deframer_top.sv]
// Channel  | Ports                        | Contents
// ---------+------------------------------+------------------------------------------
// Input    | s_tvalid s_tready s_tdata    | tdata: data_byte; tuser: req_type
//          | s_tuser                      |
// Result   | m_tvalid m_tready m_tdata    | tdata: payload_byte, total_length,
//          | m_tuser                      | image_width, image_height; tuser: kind
//
// One request is taken every cycle while the queue is not full; the parser updates its
// counters once per accepted request. A result reaches the master side via the queue
// and then the output register.
// The queue holds four results; the slave side stalls only while it is full.
// Reset is synchronous and active low and leaves the block ready for a new file.
`include "assert_macros.svh"

module png_chunk_deframer_top
    import pcd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [7:0] payload_byte, [39:8] total_length,
                                    // [71:40] image_width, [103:72] image_height
    output logic [1:0]   m_tuser    // [1:0] kind
);

    logic      in_accept;
    logic      res_valid;
    result_t   res;
    result_t   q_data;
    result_t   out_data;
    logic      q_pop;
    q_status_t q_status;

    assign s_tready  = !q_status.full;
    assign in_accept = s_tvalid && s_tready;

    // Front: parses each request and produces at most one result.
    pcd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_eof    (s_tuser),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // Short queue between parser and output stage.
    pcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop       (q_pop),
        .pop_data  (q_data),
        .status    (q_status)
    );

    // Back: registered result towards the master side.
    pcd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.height, out_data.width, out_data.total, out_data.payload};
    assign m_tuser = out_data.kind;

    // Checks on the queue and result contents.
    `ASSERT_NEVER(a_queue_bound, aclk, aresetn, q_status.count > QCNT_W'(QDEPTH), "queue count exceeds depth")
    `ASSERT_CLKD(a_valid_from_queue, aclk, aresetn, $rose(m_tvalid) |-> $past(!q_status.empty), "result shown without a queued entry")
    `ASSERT_CLKD(a_payload_zero, aclk, aresetn, (m_tvalid && (m_tuser != KIND_IDAT)) |-> (m_tdata[7:0] == 8'd0), "payload set on a status result")

endmodule
